// ===== src/kbs_pkg.sv =====
package kbs_pkg;

  // fixed field widths
  localparam int COORD_W   = 32;
  localparam int SHAPE_W   = 16;
  localparam int QPOS_W    = 17;
  localparam int COEF_W    = 48;
  localparam int NODE_W    = 3 * COORD_W + 3 * SHAPE_W;
  localparam int S_TDATA_W = 168;

  // fixed-point constants
  localparam int ONE_Q14  = 16384;
  localparam int QPOS_ONE = 65536;

  // arithmetic widths
  localparam int FAC_W   = 17;   // 1 +- shape value
  localparam int WT_W    = 20;   // tangent weight, Q.14
  localparam int WM_W    = 24;   // basis matrix entry, Q.14
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int SACC_W  = 74;
  localparam int HSPLIT  = 24;   // split point of the accumulator for Horner products

  // default parameter values
  localparam int MAX_NODES_DEF     = 64;
  localparam int POS_FRAC_BITS_DEF = 16;

  // input selector on tuser
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // result status on tuser
  localparam logic STAT_OK     = 1'b0;
  localparam logic STAT_NO_NODES = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BSEG,
    ST_BRD,
    ST_BCAP,
    ST_BWM1,
    ST_BWM2,
    ST_BWRND,
    ST_BCMUL,
    ST_BCACC,
    ST_BCWR,
    ST_QRDA,
    ST_QLDA,
    ST_QMLO,
    ST_QALO,
    ST_QMHI,
    ST_QAHI,
    ST_QADD,
    ST_QST,
    ST_QOUT,
    ST_QERR
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAP,
    OP_WMUL1,
    OP_WMUL2,
    OP_WRND,
    OP_CMUL,
    OP_CACC,
    OP_CWR,
    OP_QIDX,
    OP_QLDA,
    OP_HMUL_LO,
    OP_HACC_LO,
    OP_HMUL_HI,
    OP_HACC_HI,
    OP_HADD,
    OP_QSTORE
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] k;
    logic [1:0] c;
    logic [1:0] axis;
    logic [1:0] widx;
    logic       cap_sh0;
    logic       cap_sh1;
    logic       node_rd;
    logic       coef_rd;
    logic       qsel;
    logic       out_ok;
    logic       out_err;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_stat_t;

endpackage

// ===== src/kochanek_bartels_spline_eval_unit.sv =====
// Kochanek-Bartels cubic spline evaluator. Each load transfer (tuser 0) stores
// one 3-D node with tension, bias and continuity; the transfer with tlast set
// ends the list and starts coefficient generation, which walks every segment
// slot (node count, plus one when closed_loop is 1), paced by the single
// shared multiplier and the node and coefficient memory ports; no input is
// taken meanwhile. A query (tuser 1) runs three axes, each three Horner steps
// of two partial products on the shared multiplier plus coefficient reads.
// Results leave through an output register, so the next input is accepted
// while a result waits. tuser on the result is 1 when no list has been
// loaded yet. Memories need no clearing pass after reset.
module kochanek_bartels_spline_eval_unit #(
  parameter int MAX_NODES     = kbs_pkg::MAX_NODES_DEF,
  parameter int POS_FRAC_BITS = kbs_pkg::POS_FRAC_BITS_DEF,
  parameter int CNT_W         = $clog2(MAX_NODES + 1),
  parameter int M_TDATA_W     = ((3 * kbs_pkg::COORD_W + CNT_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // node_x, node_y, node_z, node_tension, node_bias, node_continuity, query_pos
  input  logic [kbs_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // cmd
  input  logic                          s_axis_tuser,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pos_x, pos_y, pos_z, segment_index
  output logic [M_TDATA_W-1:0]          m_axis_tdata,
  // status
  output logic                          m_axis_tuser
);
  import kbs_pkg::*;

  localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  dp_cmd_t                   cmd;
  dp_stat_t                  stat;
  logic                      node_we;
  logic [NODE_AW-1:0]        node_waddr;
  logic [NODE_AW-1:0]        node_raddr;
  logic [CNT_W-1:0]          seg;
  logic [CNT_W-1:0]          seg_total;
  logic signed [COORD_W-1:0] pos_x, pos_y, pos_z;
  logic [CNT_W-1:0]          segment_index;

  kbs_ctrl #(
    .MAX_NODES (MAX_NODES),
    .CNT_W     (CNT_W),
    .NODE_AW   (NODE_AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_valid     (s_axis_tvalid),
    .s_ready     (s_axis_tready),
    .s_cmd       (s_axis_tuser),
    .s_last      (s_axis_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .node_we     (node_we),
    .node_waddr  (node_waddr),
    .node_raddr  (node_raddr),
    .seg         (seg),
    .seg_total   (seg_total)
  );

  kbs_datapath #(
    .MAX_NODES     (MAX_NODES),
    .POS_FRAC_BITS (POS_FRAC_BITS),
    .CNT_W         (CNT_W),
    .NODE_AW       (NODE_AW)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .node_we         (node_we),
    .node_waddr      (node_waddr),
    .node_raddr      (node_raddr),
    .seg             (seg),
    .seg_total       (seg_total),
    .node_x          (s_axis_tdata[31:0]),
    .node_y          (s_axis_tdata[63:32]),
    .node_z          (s_axis_tdata[95:64]),
    .node_tension    (s_axis_tdata[111:96]),
    .node_bias       (s_axis_tdata[127:112]),
    .node_continuity (s_axis_tdata[143:128]),
    .query_pos       (s_axis_tdata[160:144]),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .pos_z           (pos_z),
    .segment_index   (segment_index),
    .status          (m_axis_tuser),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready)
  );

  // result packing, zero fill to whole bytes
  assign m_axis_tdata = M_TDATA_W'({segment_index, pos_z, pos_y, pos_x});

endmodule

// ===== src/kbs_datapath.sv =====
module kbs_datapath #(
  parameter int MAX_NODES     = kbs_pkg::MAX_NODES_DEF,
  parameter int POS_FRAC_BITS = kbs_pkg::POS_FRAC_BITS_DEF,
  parameter int CNT_W         = $clog2(MAX_NODES + 1),
  parameter int NODE_AW       = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  kbs_pkg::dp_cmd_t                     cmd,
  output kbs_pkg::dp_stat_t                    stat,
  input  logic                                 node_we,
  input  logic [NODE_AW-1:0]                   node_waddr,
  input  logic [NODE_AW-1:0]                   node_raddr,
  input  logic [CNT_W-1:0]                     seg,
  input  logic [CNT_W-1:0]                     seg_total,
  input  logic signed [kbs_pkg::COORD_W-1:0]   node_x,
  input  logic signed [kbs_pkg::COORD_W-1:0]   node_y,
  input  logic signed [kbs_pkg::COORD_W-1:0]   node_z,
  input  logic signed [kbs_pkg::SHAPE_W-1:0]   node_tension,
  input  logic signed [kbs_pkg::SHAPE_W-1:0]   node_bias,
  input  logic signed [kbs_pkg::SHAPE_W-1:0]   node_continuity,
  input  logic [kbs_pkg::QPOS_W-1:0]           query_pos,
  output logic signed [kbs_pkg::COORD_W-1:0]   pos_x,
  output logic signed [kbs_pkg::COORD_W-1:0]   pos_y,
  output logic signed [kbs_pkg::COORD_W-1:0]   pos_z,
  output logic [CNT_W-1:0]                     segment_index,
  output logic                                 status,
  output logic                                 out_valid,
  input  logic                                 out_ready
);
  import kbs_pkg::*;

  localparam int COEF_DEPTH = (MAX_NODES + 1) * 12;
  localparam int COEF_AW    = $clog2(COEF_DEPTH);
  localparam int PQ_W       = QPOS_W + CNT_W;
  localparam int SH_UP      = (POS_FRAC_BITS >= 16) ? POS_FRAC_BITS - 16 : 0;
  localparam int SH_DN      = (POS_FRAC_BITS < 16) ? 16 - POS_FRAC_BITS : 0;
  localparam int SUM_W      = SACC_W + 1;

  localparam logic signed [FAC_W-1:0]   ONE_F   = FAC_W'(ONE_Q14);
  localparam logic signed [WM_W-1:0]    ONE_M   = WM_W'(ONE_Q14);
  localparam logic signed [WM_W-1:0]    TWO_M   = WM_W'(2 * ONE_Q14);
  localparam logic signed [WM_W-1:0]    THREE_M = WM_W'(3 * ONE_Q14);
  localparam logic signed [MUL_P_W-1:0] HALF_W  = MUL_P_W'(1) << 28;
  localparam logic signed [SACC_W-1:0]  HALF_C  = SACC_W'(1) << 13;
  localparam logic signed [SACC_W-1:0]  HALF_F  = SACC_W'(1) << (POS_FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0]   S48_MAX = (SUM_W'(1) << (COEF_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0]   S48_MIN = -(SUM_W'(1) << (COEF_W - 1));
  localparam logic signed [COEF_W-1:0]  S32_MAX = (COEF_W'(1) << (COORD_W - 1)) - COEF_W'(1);
  localparam logic signed [COEF_W-1:0]  S32_MIN = -(COEF_W'(1) << (COORD_W - 1));

  // memories
  logic [NODE_W-1:0]        node_mem [MAX_NODES];
  logic [NODE_W-1:0]        node_rd_data;
  logic signed [COEF_W-1:0] coef_mem [COEF_DEPTH];
  logic signed [COEF_W-1:0] coef_rd_data;
  logic [COEF_AW-1:0]       coef_addr;
  logic signed [COEF_W-1:0] coef_wdata;

  // working registers
  logic [3*COORD_W-1:0]      preg [4];
  logic [3*SHAPE_W-1:0]      sh0;
  logic [3*SHAPE_W-1:0]      sh1;
  logic signed [WT_W-1:0]    wt [4];
  logic signed [MUL_P_W-1:0] mreg;
  logic signed [SACC_W-1:0]  sacc;
  logic signed [COEF_W-1:0]  acc;
  logic [CNT_W-1:0]          qidx;
  logic [POS_FRAC_BITS-1:0]  frac;
  logic signed [COORD_W-1:0] pos_acc [3];

  // combinational signals
  logic signed [FAC_W-1:0]   f0, f1, f2;
  logic signed [SHAPE_W-1:0] t0, b0, c0, t1, b1, c1;
  logic signed [WM_W-1:0]    ta, tb, tc, td, wsel;
  logic signed [COORD_W-1:0] psel;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [MUL_P_W-1:0] wrnd;
  logic signed [SACC_W-1:0]  crnd;
  logic signed [SACC_W-1:0]  hrnd;
  logic signed [SUM_W-1:0]   hsum;
  logic signed [COEF_W-1:0]  hsat;
  logic signed [COEF_W-1:0]  acc32;
  logic [QPOS_W-1:0]         qc;
  logic [PQ_W-1:0]           pq;
  logic [PQ_W-17:0]          idx_raw;
  logic [CNT_W-1:0]          idx_clamp;
  logic [POS_FRAC_BITS-1:0]  frac_next;
  logic [CNT_W-1:0]          seg_sel;

  assign stat.out_full = out_valid & ~out_ready;

  // node store, one entry per node
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= {node_continuity, node_bias, node_tension, node_z, node_y, node_x};
    end
    if (cmd.node_rd) begin
      node_rd_data <= node_mem[node_raddr];
    end
  end

  // coefficient store, addressed by slot, coefficient and axis
  assign seg_sel   = cmd.qsel ? qidx : seg;
  assign coef_addr = COEF_AW'(seg_sel) * COEF_AW'(12) + COEF_AW'(cmd.c) * COEF_AW'(3)
                   + COEF_AW'(cmd.axis);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CWR) begin
      coef_mem[coef_addr] <= coef_wdata;
    end
    if (cmd.coef_rd) begin
      coef_rd_data <= coef_mem[coef_addr];
    end
  end

  // shape factors for the weight being formed
  assign t0 = sh0[SHAPE_W-1:0];
  assign b0 = sh0[2*SHAPE_W-1:SHAPE_W];
  assign c0 = sh0[3*SHAPE_W-1:2*SHAPE_W];
  assign t1 = sh1[SHAPE_W-1:0];
  assign b1 = sh1[2*SHAPE_W-1:SHAPE_W];
  assign c1 = sh1[3*SHAPE_W-1:2*SHAPE_W];

  always_comb begin
    case (cmd.widx)
      2'd0: begin
        f0 = ONE_F - FAC_W'(t0);
        f1 = ONE_F + FAC_W'(b0);
        f2 = ONE_F + FAC_W'(c0);
      end
      2'd1: begin
        f0 = ONE_F - FAC_W'(t0);
        f1 = ONE_F - FAC_W'(b0);
        f2 = ONE_F - FAC_W'(c0);
      end
      2'd2: begin
        f0 = ONE_F - FAC_W'(t1);
        f1 = ONE_F + FAC_W'(b1);
        f2 = ONE_F - FAC_W'(c1);
      end
      default: begin
        f0 = ONE_F - FAC_W'(t1);
        f1 = ONE_F - FAC_W'(b1);
        f2 = ONE_F + FAC_W'(c1);
      end
    endcase
  end

  // basis matrix entry for coefficient c, node k
  assign ta = WM_W'(wt[0]);
  assign tb = WM_W'(wt[1]);
  assign tc = WM_W'(wt[2]);
  assign td = WM_W'(wt[3]);

  always_comb begin
    case ({cmd.c, cmd.k})
      4'h0:    wsel = -ta;
      4'h1:    wsel = ta - tb - tc + TWO_M;
      4'h2:    wsel = tb + tc - td - TWO_M;
      4'h3:    wsel = td;
      4'h4:    wsel = ta + ta;
      4'h5:    wsel = -(ta + ta) + tb + tb + tc - THREE_M;
      4'h6:    wsel = -(tb + tb) - tc + td + THREE_M;
      4'h7:    wsel = -td;
      4'h8:    wsel = -ta;
      4'h9:    wsel = ta - tb;
      4'hA:    wsel = tb;
      4'hD:    wsel = ONE_M;
      default: wsel = '0;
    endcase
  end

  // coordinate of node k on the current axis
  always_comb begin
    case (cmd.axis)
      2'd1:    psel = preg[cmd.k][2*COORD_W-1:COORD_W];
      2'd2:    psel = preg[cmd.k][3*COORD_W-1:2*COORD_W];
      default: psel = preg[cmd.k][COORD_W-1:0];
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    case (cmd.op)
      OP_WMUL1: begin
        mul_a = MUL_A_W'(f0);
        mul_b = MUL_B_W'(f1);
      end
      OP_WMUL2: begin
        mul_a = mreg[MUL_A_W-1:0];
        mul_b = MUL_B_W'(f2);
      end
      OP_CMUL: begin
        mul_a = MUL_A_W'(psel);
        mul_b = MUL_B_W'(wsel);
      end
      OP_HMUL_LO: begin
        mul_a = $signed({{(MUL_A_W-HSPLIT){1'b0}}, acc[HSPLIT-1:0]});
        mul_b = $signed({{(MUL_B_W-POS_FRAC_BITS){1'b0}}, frac});
      end
      OP_HMUL_HI: begin
        mul_a = MUL_A_W'($signed(acc[COEF_W-1:HSPLIT]));
        mul_b = $signed({{(MUL_B_W-POS_FRAC_BITS){1'b0}}, frac});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // rounding and saturation
  assign wrnd = (mreg + HALF_W) >>> 29;
  assign crnd = (sacc + HALF_C) >>> 14;
  assign hrnd = (sacc + HALF_F) >>> POS_FRAC_BITS;
  assign hsum = SUM_W'(hrnd) + SUM_W'(coef_rd_data);

  always_comb begin
    if (SUM_W'(crnd) > S48_MAX) begin
      coef_wdata = S48_MAX[COEF_W-1:0];
    end else if (SUM_W'(crnd) < S48_MIN) begin
      coef_wdata = S48_MIN[COEF_W-1:0];
    end else begin
      coef_wdata = crnd[COEF_W-1:0];
    end
    if (hsum > S48_MAX) begin
      hsat = S48_MAX[COEF_W-1:0];
    end else if (hsum < S48_MIN) begin
      hsat = S48_MIN[COEF_W-1:0];
    end else begin
      hsat = hsum[COEF_W-1:0];
    end
    if (acc > S32_MAX) begin
      acc32 = S32_MAX;
    end else if (acc < S32_MIN) begin
      acc32 = S32_MIN;
    end else begin
      acc32 = acc;
    end
  end

  // query parameter split into segment and fraction
  assign qc        = (query_pos > QPOS_W'(QPOS_ONE)) ? QPOS_W'(QPOS_ONE) : query_pos;
  assign pq        = PQ_W'(qc) * PQ_W'(seg_total);
  assign idx_raw   = pq[PQ_W-1:16];
  assign idx_clamp = (idx_raw > (PQ_W-16)'(seg_total)) ? seg_total : idx_raw[CNT_W-1:0];
  assign frac_next = POS_FRAC_BITS'((40'(pq[15:0]) << SH_UP) >> SH_DN);

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAP: begin
        preg[cmd.k] <= node_rd_data[3*COORD_W-1:0];
        if (cmd.cap_sh0) begin
          sh0 <= node_rd_data[NODE_W-1:3*COORD_W];
        end
        if (cmd.cap_sh1) begin
          sh1 <= node_rd_data[NODE_W-1:3*COORD_W];
        end
      end
      OP_WMUL1, OP_WMUL2, OP_CMUL, OP_HMUL_LO, OP_HMUL_HI: begin
        mreg <= mul_p;
      end
      OP_WRND: begin
        wt[cmd.widx] <= wrnd[WT_W-1:0];
      end
      OP_CACC: begin
        sacc <= ((cmd.k == 2'd0) ? SACC_W'(0) : sacc) + SACC_W'(mreg);
      end
      OP_QIDX: begin
        qidx <= idx_clamp;
        frac <= frac_next;
      end
      OP_QLDA: begin
        acc <= coef_rd_data;
      end
      OP_HACC_LO: begin
        sacc <= SACC_W'(mreg);
      end
      OP_HACC_HI: begin
        sacc <= sacc + (SACC_W'(mreg) <<< HSPLIT);
      end
      OP_HADD: begin
        acc <= hsat;
      end
      OP_QSTORE: begin
        pos_acc[cmd.axis] <= acc32[COORD_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ok || cmd.out_err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ok) begin
      pos_x         <= pos_acc[0];
      pos_y         <= pos_acc[1];
      pos_z         <= pos_acc[2];
      segment_index <= qidx;
      status        <= STAT_OK;
    end else if (cmd.out_err) begin
      pos_x         <= '0;
      pos_y         <= '0;
      pos_z         <= '0;
      segment_index <= '0;
      status        <= STAT_NO_NODES;
    end
  end

endmodule

// ===== src/kbs_ctrl.sv =====
module kbs_ctrl #(
  parameter int MAX_NODES = kbs_pkg::MAX_NODES_DEF,
  parameter int CNT_W     = $clog2(MAX_NODES + 1),
  parameter int NODE_AW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_valid,
  output logic               s_ready,
  input  logic               s_cmd,
  input  logic               s_last,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  output kbs_pkg::dp_cmd_t   cmd,
  input  kbs_pkg::dp_stat_t  stat,
  output logic               node_we,
  output logic [NODE_AW-1:0] node_waddr,
  output logic [NODE_AW-1:0] node_raddr,
  output logic [CNT_W-1:0]   seg,
  output logic [CNT_W-1:0]   seg_total
);
  import kbs_pkg::*;

  localparam int RK_W = CNT_W + 2;

  ctl_state_t state, state_next;

  logic                   closed_loop;
  logic                   wrap_b;
  logic [CNT_W-1:0]       load_ptr;
  logic [CNT_W-1:0]       node_cnt;
  logic [CNT_W-1:0]       seg_i;
  logic signed [RK_W-1:0] rk;
  logic [NODE_AW-1:0]     wk;
  logic [1:0]             k;
  logic [1:0]             c;
  logic [1:0]             axis;
  logic [1:0]             widx;

  logic                   ptr_room;
  logic [CNT_W-1:0]       ptr_new;
  logic                   last_slot;
  logic [NODE_AW-1:0]     clamp_idx;
  logic [NODE_AW-1:0]     n_last;

  assign s_ready    = (state == ST_IDLE);
  assign ptr_room   = (load_ptr < CNT_W'(MAX_NODES));
  assign ptr_new    = load_ptr + CNT_W'(ptr_room);
  assign node_waddr = load_ptr[NODE_AW-1:0];
  assign seg        = seg_i;
  assign n_last     = NODE_AW'(node_cnt - CNT_W'(1));
  assign last_slot  = wrap_b ? (seg_i == node_cnt) : (seg_i == node_cnt - CNT_W'(1));

  // node index for tap k: wrapped or clamped at the ends
  always_comb begin
    if (rk < 0) begin
      clamp_idx = '0;
    end else if (rk >= $signed({2'b00, node_cnt})) begin
      clamp_idx = n_last;
    end else begin
      clamp_idx = rk[NODE_AW-1:0];
    end
  end

  assign node_raddr = wrap_b ? wk : clamp_idx;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next  = state;
    node_we     = 1'b0;
    cmd.op      = OP_NONE;
    cmd.k       = k;
    cmd.c       = c;
    cmd.axis    = axis;
    cmd.widx    = widx;
    cmd.cap_sh0 = 1'b0;
    cmd.cap_sh1 = 1'b0;
    cmd.node_rd = 1'b0;
    cmd.coef_rd = 1'b0;
    cmd.qsel    = 1'b0;
    cmd.out_ok  = 1'b0;
    cmd.out_err = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_valid) begin
          if (s_cmd == CMD_LOAD) begin
            node_we = ptr_room;
            if (s_last && ptr_new != '0) begin
              state_next = ST_BSEG;
            end
          end else if (node_cnt == '0) begin
            state_next = ST_QERR;
          end else begin
            cmd.op     = OP_QIDX;
            state_next = ST_QRDA;
          end
        end
      end
      ST_BSEG: begin
        state_next = ST_BRD;
      end
      ST_BRD: begin
        cmd.node_rd = 1'b1;
        state_next  = ST_BCAP;
      end
      ST_BCAP: begin
        cmd.op      = OP_CAP;
        cmd.cap_sh0 = (k == 2'd1);
        cmd.cap_sh1 = (k == 2'd1) || (k == 2'd2 && !last_slot);
        state_next  = (k == 2'd3) ? ST_BWM1 : ST_BRD;
      end
      ST_BWM1: begin
        cmd.op     = OP_WMUL1;
        state_next = ST_BWM2;
      end
      ST_BWM2: begin
        cmd.op     = OP_WMUL2;
        state_next = ST_BWRND;
      end
      ST_BWRND: begin
        cmd.op     = OP_WRND;
        state_next = (widx == 2'd3) ? ST_BCMUL : ST_BWM1;
      end
      ST_BCMUL: begin
        cmd.op     = OP_CMUL;
        state_next = ST_BCACC;
      end
      ST_BCACC: begin
        cmd.op     = OP_CACC;
        state_next = (k == 2'd3) ? ST_BCWR : ST_BCMUL;
      end
      ST_BCWR: begin
        cmd.op = OP_CWR;
        if (c == 2'd3 && axis == 2'd2) begin
          state_next = last_slot ? ST_IDLE : ST_BSEG;
        end else begin
          state_next = ST_BCMUL;
        end
      end
      ST_QRDA: begin
        cmd.coef_rd = 1'b1;
        cmd.qsel    = 1'b1;
        cmd.c       = 2'd0;
        state_next  = ST_QLDA;
      end
      ST_QLDA: begin
        cmd.op     = OP_QLDA;
        state_next = ST_QMLO;
      end
      ST_QMLO: begin
        cmd.op      = OP_HMUL_LO;
        cmd.coef_rd = 1'b1;
        cmd.qsel    = 1'b1;
        state_next  = ST_QALO;
      end
      ST_QALO: begin
        cmd.op     = OP_HACC_LO;
        state_next = ST_QMHI;
      end
      ST_QMHI: begin
        cmd.op     = OP_HMUL_HI;
        state_next = ST_QAHI;
      end
      ST_QAHI: begin
        cmd.op     = OP_HACC_HI;
        state_next = ST_QADD;
      end
      ST_QADD: begin
        cmd.op     = OP_HADD;
        state_next = (c == 2'd3) ? ST_QST : ST_QMLO;
      end
      ST_QST: begin
        cmd.op     = OP_QSTORE;
        state_next = (axis == 2'd2) ? ST_QOUT : ST_QRDA;
      end
      ST_QOUT: begin
        if (!stat.out_full) begin
          cmd.out_ok = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_QERR: begin
        if (!stat.out_full) begin
          cmd.out_err = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      closed_loop <= 1'b0;
    end else if (cfg_wr_en) begin
      closed_loop <= cfg_wr_data;
    end
  end

  // counters and list bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      load_ptr  <= '0;
      node_cnt  <= '0;
      seg_total <= '0;
      wrap_b    <= 1'b0;
      seg_i     <= '0;
      rk        <= '0;
      wk        <= '0;
      k         <= '0;
      c         <= '0;
      axis      <= '0;
      widx      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_valid) begin
            if (s_cmd == CMD_LOAD) begin
              if (s_last) begin
                load_ptr <= '0;
                node_cnt <= ptr_new;
                wrap_b   <= closed_loop;
                seg_i    <= '0;
              end else begin
                load_ptr <= ptr_new;
              end
            end else begin
              axis <= '0;
            end
          end
        end
        ST_BSEG: begin
          rk <= $signed({2'b00, seg_i}) - RK_W'(1);
          wk <= (seg_i == '0) ? n_last : NODE_AW'(seg_i - CNT_W'(1));
          k  <= '0;
        end
        ST_BCAP: begin
          rk   <= rk + RK_W'(1);
          wk   <= (wk == n_last) ? '0 : wk + NODE_AW'(1);
          k    <= k + 2'd1;
          widx <= '0;
        end
        ST_BWRND: begin
          widx <= widx + 2'd1;
          axis <= '0;
          c    <= '0;
          k    <= '0;
        end
        ST_BCACC: begin
          k <= k + 2'd1;
        end
        ST_BCWR: begin
          c <= c + 2'd1;
          if (c == 2'd3) begin
            axis <= axis + 2'd1;
            if (axis == 2'd2) begin
              if (last_slot) begin
                seg_total <= wrap_b ? node_cnt : node_cnt - CNT_W'(1);
              end else begin
                seg_i <= seg_i + CNT_W'(1);
              end
            end
          end
        end
        ST_QLDA: begin
          c <= 2'd1;
        end
        ST_QADD: begin
          c <= c + 2'd1;
        end
        ST_QST: begin
          axis <= axis + 2'd1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
